// File: hdl/assert_macros.svh
// Assertion macros shared by checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/imuacf_pkg.sv
// ----------------------------------------------------------------------------
// imuacf_pkg
// Shared types and constants of the attitude complementary filter.
// ----------------------------------------------------------------------------
`default_nettype none
package imuacf_pkg;
    localparam int QW = 72;
    typedef logic signed [QW-1:0] t_acc;

    localparam logic [15:0] KP_RESET = 16'd4096;
    localparam logic [15:0] KI_RESET = 16'd0;
    localparam logic [15:0] DT_RESET = 16'd1049;

    localparam logic [1:0] REG_KP = 2'd0;
    localparam logic [1:0] REG_KI = 2'd1;
    localparam logic [1:0] REG_DT = 2'd2;

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;
    localparam logic signed [QW-1:0] HALF_LIM = 72'sd536870912;
    localparam logic signed [QW-1:0] I32_MAX = 72'sd2147483647;
    localparam logic signed [QW-1:0] I32_MIN = -72'sd2147483648;

    // Rounded arithmetic right shift, ties away from zero
    function automatic t_acc rsr(input t_acc v, input logic [5:0] n);
        t_acc m;
        t_acc h;
        begin
            m = v[QW-1] ? -v : v;
            h = t_acc'(1) <<< (n - 6'd1);
            m = (m + h) >>> n;
            rsr = v[QW-1] ? -m : m;
        end
    endfunction
endpackage
`default_nettype wire

// File: hdl/imuacf_mul.sv
// ----------------------------------------------------------------------------
// imuacf_mul
// Shared registered 32x32 signed multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module imuacf_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [63:0]      o_p
);
    logic signed [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

// File: hdl/imuacf_div.sv
// ----------------------------------------------------------------------------
// imuacf_div
// Bit-serial unit: integer square root or rounded division, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module imuacf_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_sqrt,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_res
);
    // division: quotient of (2m + d) / (2d), 66-bit numerator
    logic        r_busy, r_sqrt, r_done;
    logic [6:0]  r_cnt;
    logic [65:0] r_rem, r_num, r_den;
    logic [63:0] r_q;
    logic [65:0] n_rem, n_trial;
    logic [65:0] sq_t;

    always_comb begin
        n_rem   = {r_rem[64:0], r_num[65]};
        n_trial = n_rem - r_den;
        sq_t    = {r_rem[63:0], r_num[65:64]} - {r_q[63:0], 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_sqrt;
                r_rem  <= '0;
                r_q    <= '0;
                if (i_sqrt) begin
                    r_num <= {2'b00, i_num};
                    r_cnt <= 7'd33;
                end else begin
                    r_num <= {1'b0, i_num, 1'b0} + {2'b00, i_den};
                    r_den <= {1'b0, i_den, 1'b0};
                    r_cnt <= 7'd66;
                end
            end else if (r_busy) begin
                if (r_sqrt) begin
                    if (!sq_t[65]) begin
                        r_rem <= sq_t;
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[63:0], r_num[65:64]};
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                    r_num <= {r_num[63:0], 2'b00};
                end else begin
                    if (n_rem >= r_den) begin
                        r_rem <= n_trial;
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                    r_num <= {r_num[64:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_res  = r_q;
endmodule
`default_nettype wire

// File: hdl/imu_attitude_complementary_filter_top.sv
// Mahony attitude filter. One beat in, one quaternion beat out, and no new input beat
// is taken until the result beat has been taken. Between the accepted input beat
// and o_valid lie 46 steps through the shared registered multiplier, plus two
// square roots (33 iterations each) and seven rounded divisions (66 iterations
// each) in the one bit-serial divide/root unit. A zero accel vector skips the
// accel normalization and the correction. o_stall is low only while the block
// is idle and no result waits in its output register.
// ----------------------------------------------------------------------------
// imu_attitude_complementary_filter_top
// Sequencer around a shared multiplier and a shared divide/root unit.
// ----------------------------------------------------------------------------
`default_nettype none
module imu_attitude_complementary_filter_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_gyro_x,
    input  wire logic signed [15:0] i_gyro_y,
    input  wire logic signed [15:0] i_gyro_z,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_quat_w,
    output logic signed [15:0]      o_quat_x,
    output logic signed [15:0]      o_quat_y,
    output logic signed [15:0]      o_quat_z,
    output logic                    o_accel_invalid,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    localparam int QW = imuacf_pkg::QW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_WAIT = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_DWT  = 4'd4;
    localparam logic [3:0] S_OUT  = 4'd5;

    logic [15:0] r_kp, r_ki, r_dt;
    logic signed [15:0] r_q [4];
    logic signed [31:0] r_ei [3];
    logic signed [15:0] r_g [3], r_a [3];
    logic [3:0] r_state;
    logic [6:0] r_pc;
    logic       r_inv, r_ovalid;
    logic signed [QW-1:0] r_acc;
    logic signed [QW-1:0] r_t [12];
    logic signed [15:0] r_oq [4];

    logic signed [31:0] n_ma, n_mb;
    logic signed [63:0] w_p;
    logic        n_dstart, n_dsqrt;
    logic [63:0] n_dnum, n_dden;
    logic        w_ddone;
    logic [63:0] w_dres;

    imuacf_mul u_mul (.i_clk(i_clk), .i_a(n_ma), .i_b(n_mb), .o_p(w_p));
    imuacf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_dstart), .i_sqrt(n_dsqrt),
        .i_num(n_dnum), .i_den(n_dden), .o_done(w_ddone), .o_res(w_dres)
    );

    // Microcode: each step multiplies operands A*B, combines into acc with
    // an op, or triggers a divider step. Temporaries r_t:
    // 0..2 an, 3..5 v, 6..8 e, 9..11 r / h; after update 0..3 qn, 4 norm.
    function automatic logic signed [31:0] sx(input logic signed [15:0] v);
        sx = 32'(v);
    endfunction

    logic signed [QW-1:0] w_pe;
    assign w_pe = QW'(w_p);

    // Sequence program counter stages:
    // 0..2   s = sum a^2 (mul)
    // 3      sqrt (a zero sum skips to 31)
    // 4..6   an[i] divisions
    // 10..52 products, fully listed in case below
    logic signed [31:0] pa, pb;
    logic [2:0] pop; // 0 clear+add,1 add,2 sub,3 add<<16,4 negate
    logic       plast;

    always_comb begin
        pa = '0; pb = '0; pop = 3'd1; plast = 1'b0;
        case (r_pc)
            7'd0:  begin pa = sx(r_a[0]); pb = sx(r_a[0]); pop = 3'd0; end
            7'd1:  begin pa = sx(r_a[1]); pb = sx(r_a[1]); end
            7'd2:  begin pa = sx(r_a[2]); pb = sx(r_a[2]); plast = 1'b1; end
            // v0 = 2(xz - wy)
            7'd10: begin pa = sx(r_q[1]); pb = sx(r_q[3]); pop = 3'd0; end
            7'd11: begin pa = sx(r_q[0]); pb = sx(r_q[2]); pop = 3'd2; plast = 1'b1; end
            7'd12: begin pa = sx(r_q[2]); pb = sx(r_q[3]); pop = 3'd0; end
            7'd13: begin pa = sx(r_q[0]); pb = sx(r_q[1]); plast = 1'b1; end
            7'd14: begin pa = sx(r_q[1]); pb = sx(r_q[1]); pop = 3'd0; end
            7'd15: begin pa = sx(r_q[2]); pb = sx(r_q[2]); plast = 1'b1; end
            // e0 = an1 v2 - an2 v1
            7'd16: begin pa = r_t[1][31:0]; pb = r_t[5][31:0]; pop = 3'd0; end
            7'd17: begin pa = r_t[2][31:0]; pb = r_t[4][31:0]; pop = 3'd2; plast = 1'b1; end
            7'd18: begin pa = r_t[2][31:0]; pb = r_t[3][31:0]; pop = 3'd0; end
            7'd19: begin pa = r_t[0][31:0]; pb = r_t[5][31:0]; pop = 3'd2; plast = 1'b1; end
            7'd20: begin pa = r_t[0][31:0]; pb = r_t[4][31:0]; pop = 3'd0; end
            7'd21: begin pa = r_t[1][31:0]; pb = r_t[3][31:0]; pop = 3'd2; plast = 1'b1; end
            // integral update e*dt
            7'd22: begin pa = r_t[6][31:0]; pb = {16'd0, r_dt}; pop = 3'd0; plast = 1'b1; end
            7'd23: begin pa = r_t[7][31:0]; pb = {16'd0, r_dt}; pop = 3'd0; plast = 1'b1; end
            7'd24: begin pa = r_t[8][31:0]; pb = {16'd0, r_dt}; pop = 3'd0; plast = 1'b1; end
            // rate: kp*e and ki*I
            7'd25: begin pa = r_t[6][31:0]; pb = {16'd0, r_kp}; pop = 3'd0; plast = 1'b1; end
            7'd26: begin pa = r_ei[0]; pb = {16'd0, r_ki}; pop = 3'd0; plast = 1'b1; end
            7'd27: begin pa = r_t[7][31:0]; pb = {16'd0, r_kp}; pop = 3'd0; plast = 1'b1; end
            7'd28: begin pa = r_ei[1]; pb = {16'd0, r_ki}; pop = 3'd0; plast = 1'b1; end
            7'd29: begin pa = r_t[8][31:0]; pb = {16'd0, r_kp}; pop = 3'd0; plast = 1'b1; end
            7'd30: begin pa = r_ei[2]; pb = {16'd0, r_ki}; pop = 3'd0; plast = 1'b1; end
            // h = r*dt (r wider than 32 bits: split into high and low halves)
            7'd31: begin pa = {16'd0, r_t[9][15:0]};  pb = {16'd0, r_dt}; pop = 3'd0; end
            7'd32: begin pa = r_t[9][47:16];  pb = {16'd0, r_dt}; pop = 3'd3; plast = 1'b1; end
            7'd33: begin pa = {16'd0, r_t[10][15:0]}; pb = {16'd0, r_dt}; pop = 3'd0; end
            7'd34: begin pa = r_t[10][47:16]; pb = {16'd0, r_dt}; pop = 3'd3; plast = 1'b1; end
            7'd35: begin pa = {16'd0, r_t[11][15:0]}; pb = {16'd0, r_dt}; pop = 3'd0; end
            7'd36: begin pa = r_t[11][47:16]; pb = {16'd0, r_dt}; pop = 3'd3; plast = 1'b1; end
            // qn0 = -x h0 - y h1 - z h2
            7'd37: begin pa = sx(r_q[1]); pb = r_t[9][31:0];  pop = 3'd4; end
            7'd38: begin pa = sx(r_q[2]); pb = r_t[10][31:0]; pop = 3'd2; end
            7'd39: begin pa = sx(r_q[3]); pb = r_t[11][31:0]; pop = 3'd2; plast = 1'b1; end
            7'd40: begin pa = sx(r_q[0]); pb = r_t[9][31:0];  pop = 3'd0; end
            7'd41: begin pa = sx(r_q[2]); pb = r_t[11][31:0]; end
            7'd42: begin pa = sx(r_q[3]); pb = r_t[10][31:0]; pop = 3'd2; plast = 1'b1; end
            7'd43: begin pa = sx(r_q[0]); pb = r_t[10][31:0]; pop = 3'd0; end
            7'd44: begin pa = sx(r_q[1]); pb = r_t[11][31:0]; pop = 3'd2; end
            7'd45: begin pa = sx(r_q[3]); pb = r_t[9][31:0];  plast = 1'b1; end
            7'd46: begin pa = sx(r_q[0]); pb = r_t[11][31:0]; pop = 3'd0; end
            7'd47: begin pa = sx(r_q[1]); pb = r_t[10][31:0]; end
            7'd48: begin pa = sx(r_q[2]); pb = r_t[9][31:0];  pop = 3'd2; plast = 1'b1; end
            // sum of squares of qn (values up to ~2^31)
            7'd49: begin pa = r_t[0][31:0]; pb = r_t[0][31:0]; pop = 3'd0; end
            7'd50: begin pa = r_t[1][31:0]; pb = r_t[1][31:0]; end
            7'd51: begin pa = r_t[2][31:0]; pb = r_t[2][31:0]; end
            7'd52: begin pa = r_t[3][31:0]; pb = r_t[3][31:0]; plast = 1'b1; end
            default: begin pa = '0; pb = '0; end
        endcase
    end

    assign n_ma = pa;
    assign n_mb = pb;

    logic signed [QW-1:0] n_acc;
    always_comb begin
        case (pop)
            3'd0:    n_acc = w_pe;
            3'd2:    n_acc = r_acc - w_pe;
            3'd3:    n_acc = r_acc + (w_pe <<< 16);
            3'd4:    n_acc = -w_pe;
            default: n_acc = r_acc + w_pe;
        endcase
    end

    // divide/root request for current pc
    logic [63:0] w_mag;
    logic [1:0]  w_di;
    always_comb begin
        n_dsqrt = 1'b0; n_dnum = '0; n_dden = '0; w_di = '0;
        case (r_pc)
            7'd3:  begin n_dsqrt = 1'b1; n_dnum = r_acc[63:0]; end
            7'd4, 7'd5, 7'd6: begin
                w_di   = 2'(r_pc - 7'd4);
                n_dnum = 64'(r_a[w_di] < 0 ? -(QW'(r_a[w_di])) : QW'(r_a[w_di])) << 14;
                n_dden = r_t[4][63:0];
            end
            7'd53: begin n_dsqrt = 1'b1; n_dnum = r_acc[63:0]; end
            7'd54, 7'd55, 7'd56, 7'd57: begin
                w_di   = 2'(r_pc - 7'd54);
                n_dnum = 64'(r_t[w_di][QW-1] ? -r_t[w_di] : r_t[w_di]) << 14;
                n_dden = r_t[4][63:0];
            end
            default: ;
        endcase
        w_mag = w_dres;
    end

    // the sign for a division comes from its numerator
    logic w_neg;
    always_comb begin
        if (r_pc <= 7'd6) w_neg = r_a[w_di] < 0;
        else              w_neg = r_t[w_di][QW-1];
    end

    logic signed [QW-1:0] w_sres;
    assign w_sres = w_neg ? -QW'(w_mag) : QW'(w_mag);

    // saturated integral update
    logic signed [QW-1:0] w_isum;
    logic [1:0] w_ii;
    assign w_ii = 2'(r_pc - 7'd22);
    assign w_isum = QW'(r_ei[w_ii]) + imuacf_pkg::rsr(n_acc, 6'd20);

    assign n_dstart = (r_state == S_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_kp <= imuacf_pkg::KP_RESET;
            r_ki <= imuacf_pkg::KI_RESET;
            r_dt <= imuacf_pkg::DT_RESET;
            r_q[0] <= imuacf_pkg::Q14_ONE;
            r_q[1] <= '0; r_q[2] <= '0; r_q[3] <= '0;
            r_ei[0] <= '0; r_ei[1] <= '0; r_ei[2] <= '0;
            r_pc <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    imuacf_pkg::REG_KP: r_kp <= i_cfg_data;
                    imuacf_pkg::REG_KI: r_ki <= i_cfg_data;
                    imuacf_pkg::REG_DT: r_dt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_g[0] <= i_gyro_x; r_g[1] <= i_gyro_y; r_g[2] <= i_gyro_z;
                        r_a[0] <= i_accel_x; r_a[1] <= i_accel_y; r_a[2] <= i_accel_z;
                        r_pc <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_acc <= n_acc;
                    if (!plast) begin
                        r_pc <= r_pc + 7'd1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_MUL;
                        r_pc <= r_pc + 7'd1;
                        case (r_pc)
                            7'd2: begin
                                r_inv <= (n_acc == 0);
                                if (n_acc == 0) begin
                                    r_t[9]  <= QW'(r_g[0]) <<< 12;
                                    r_t[10] <= QW'(r_g[1]) <<< 12;
                                    r_t[11] <= QW'(r_g[2]) <<< 12;
                                    r_pc <= 7'd31;
                                end else begin
                                    r_pc <= 7'd3;
                                    r_state <= S_DIV;
                                end
                            end
                            7'd11: r_t[3] <= imuacf_pkg::rsr(n_acc <<< 1, 6'd14);
                            7'd13: r_t[4] <= imuacf_pkg::rsr(n_acc <<< 1, 6'd14);
                            7'd15: r_t[5] <= imuacf_pkg::rsr((QW'(1) <<< 28) - (n_acc <<< 1),
                                                            6'd14);
                            7'd17: r_t[6] <= imuacf_pkg::rsr(n_acc, 6'd4);
                            7'd19: r_t[7] <= imuacf_pkg::rsr(n_acc, 6'd4);
                            7'd21: r_t[8] <= imuacf_pkg::rsr(n_acc, 6'd4);
                            7'd22, 7'd23, 7'd24: begin
                                if (w_isum > imuacf_pkg::I32_MAX)
                                    r_ei[w_ii] <= 32'sh7FFFFFFF;
                                else if (w_isum < imuacf_pkg::I32_MIN)
                                    r_ei[w_ii] <= 32'sh80000000;
                                else
                                    r_ei[w_ii] <= w_isum[31:0];
                            end
                            7'd25: r_t[9]  <= (QW'(r_g[0]) <<< 12) + imuacf_pkg::rsr(n_acc, 6'd12);
                            7'd26: r_t[9]  <= r_t[9]  + imuacf_pkg::rsr(n_acc, 6'd12);
                            7'd27: r_t[10] <= (QW'(r_g[1]) <<< 12) + imuacf_pkg::rsr(n_acc, 6'd12);
                            7'd28: r_t[10] <= r_t[10] + imuacf_pkg::rsr(n_acc, 6'd12);
                            7'd29: r_t[11] <= (QW'(r_g[2]) <<< 12) + imuacf_pkg::rsr(n_acc, 6'd12);
                            7'd30: r_t[11] <= r_t[11] + imuacf_pkg::rsr(n_acc, 6'd12);
                            7'd32, 7'd34, 7'd36: begin
                                r_t[9 + 2'(({1'b0, r_pc} - 8'd32) >> 1)] <=
                                    (imuacf_pkg::rsr(n_acc, 6'd15) > imuacf_pkg::HALF_LIM)
                                        ? imuacf_pkg::HALF_LIM
                                        : (imuacf_pkg::rsr(n_acc, 6'd15) < -imuacf_pkg::HALF_LIM)
                                            ? -imuacf_pkg::HALF_LIM
                                            : imuacf_pkg::rsr(n_acc, 6'd15);
                            end
                            7'd39: r_t[0] <= (QW'(r_q[0]) <<< 14) + imuacf_pkg::rsr(n_acc, 6'd16);
                            7'd42: r_t[1] <= (QW'(r_q[1]) <<< 14) + imuacf_pkg::rsr(n_acc, 6'd16);
                            7'd45: r_t[2] <= (QW'(r_q[2]) <<< 14) + imuacf_pkg::rsr(n_acc, 6'd16);
                            7'd48: r_t[3] <= (QW'(r_q[3]) <<< 14) + imuacf_pkg::rsr(n_acc, 6'd16);
                            7'd52: begin
                                if (n_acc == 0) r_state <= S_OUT;
                                else            r_state <= S_DIV;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    r_state <= S_DWT;
                end
                S_DWT: begin
                    if (w_ddone) begin
                        r_pc <= r_pc + 7'd1;
                        r_state <= S_DIV;
                        case (r_pc)
                            7'd3, 7'd53: r_t[4] <= QW'(w_dres);
                            7'd4, 7'd5, 7'd6: r_t[w_di] <= w_sres;
                            7'd54, 7'd55, 7'd56, 7'd57: r_oq[w_di] <= w_sres[15:0];
                            default: ;
                        endcase
                        if (r_pc == 7'd6) begin
                            r_pc <= 7'd10;
                            r_state <= S_MUL;
                        end
                        if (r_pc == 7'd57) r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_pc == 7'd58) begin
                        r_q[0] <= r_oq[0]; r_q[1] <= r_oq[1];
                        r_q[2] <= r_oq[2]; r_q[3] <= r_oq[3];
                    end
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register holds the last posted quaternion
    logic signed [15:0] r_out [4];
    logic r_oinv;
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            if (r_pc == 7'd58) begin
                r_out[0] <= r_oq[0]; r_out[1] <= r_oq[1];
                r_out[2] <= r_oq[2]; r_out[3] <= r_oq[3];
            end else begin
                r_out[0] <= r_q[0]; r_out[1] <= r_q[1];
                r_out[2] <= r_q[2]; r_out[3] <= r_q[3];
            end
            r_oinv <= r_inv;
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_quat_w = r_out[0];
    assign o_quat_x = r_out[1];
    assign o_quat_y = r_out[2];
    assign o_quat_z = r_out[3];
    assign o_accel_invalid = r_oinv;
endmodule
`default_nettype wire

// File: hdl/imuacf_checker.sv
// ----------------------------------------------------------------------------
// imuacf_checker
// Port-level checks of the attitude filter handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module imuacf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_quat_w
);
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_quat_w), "output beat dropped")
    `ASSERT_CLK(a_busy_out, i_clk, i_rst_n, o_valid |-> o_stall, "input taken while result pending")
    `ASSERT_CLK(a_acc_busy, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "not busy after accept")
    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

bind imu_attitude_complementary_filter_top imuacf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_quat_w(o_quat_w)
);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attitude filter testbench
// Sends IMU samples through the filter and checks each quaternion beat
// against a bit-exact fixed-point predictor kept in the testbench, across
// several gain and sample period settings and with random idle and stall.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               bad;
    } t_quat_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [15:0] i_gyro_x = '0, i_gyro_y = '0, i_gyro_z = '0;
    logic signed [15:0] i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    logic o_accel_invalid;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    imu_attitude_complementary_filter_top dut (.*);

    initial forever #4 i_clk = ~i_clk;

    // predictor state
    longint kp_gain, ki_gain, dt_period;
    longint att[4];
    longint err_int[3];
    t_quat_beat expected_quats[$];

    int errors = 0;
    int idle_cycles = 0;
    bit rx_jitter = 1'b1;
    bit tx_jitter = 1'b1;
    int rx_holdoff = 0;

    function automatic longint round_shift(longint v, int n);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (n - 1))) >>> n;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint m;
        m = num < 0 ? -num : num;
        m = (2 * m + den) / (2 * den);
        return num < 0 ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint sat_i32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_angle(longint v);
        if (v > (64'sd1 <<< 29)) return 64'sd1 <<< 29;
        if (v < -(64'sd1 <<< 29)) return -(64'sd1 <<< 29);
        return v;
    endfunction

    task automatic predict_attitude(input longint g[3], input longint a[3]);
        longint unsigned s;
        longint r[3], h[3], qn[4], an[3], v[3], e[3];
        longint w, x, y, z, n;
        t_quat_beat q;
        w = att[0]; x = att[1]; y = att[2]; z = att[3];
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        q.bad = (s == 0);
        if (q.bad) begin
            for (int i = 0; i < 3; i++) r[i] = g[i] * 4096;
        end else begin
            n = int_sqrt(s);
            for (int i = 0; i < 3; i++) an[i] = round_div(a[i] * 16384, n);
            v[0] = round_shift(2 * (x * z - w * y), 14);
            v[1] = round_shift(2 * (y * z + w * x), 14);
            v[2] = round_shift((64'sd1 <<< 28) - 2 * (x * x + y * y), 14);
            e[0] = round_shift(an[1] * v[2] - an[2] * v[1], 4);
            e[1] = round_shift(an[2] * v[0] - an[0] * v[2], 4);
            e[2] = round_shift(an[0] * v[1] - an[1] * v[0], 4);
            for (int i = 0; i < 3; i++) begin
                err_int[i] = sat_i32(err_int[i] + round_shift(e[i] * dt_period, 20));
                r[i] = g[i] * 4096 + round_shift(kp_gain * e[i], 12)
                     + round_shift(ki_gain * err_int[i], 12);
            end
        end
        for (int i = 0; i < 3; i++) h[i] = clamp_angle(round_shift(r[i] * dt_period, 15));
        qn[0] = w * 16384 + round_shift(-x * h[0] - y * h[1] - z * h[2], 16);
        qn[1] = x * 16384 + round_shift(w * h[0] + y * h[2] - z * h[1], 16);
        qn[2] = y * 16384 + round_shift(w * h[1] - x * h[2] + z * h[0], 16);
        qn[3] = z * 16384 + round_shift(w * h[2] + x * h[1] - y * h[0], 16);
        s = 0;
        for (int i = 0; i < 4; i++) s += qn[i] * qn[i];
        if (s != 0) begin
            n = int_sqrt(s);
            for (int i = 0; i < 4; i++) begin
                att[i] = round_div(qn[i] * 16384, n);
                att[i] = longint'(signed'(att[i][15:0]));
            end
        end
        q.w = att[0][15:0]; q.x = att[1][15:0]; q.y = att[2][15:0]; q.z = att[3][15:0];
        expected_quats.push_back(q);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_sample(input logic signed [15:0] gx, gy, gz, ax, ay, az);
        longint g[3], a[3];
        if (tx_jitter && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_gyro_x <= gx; i_gyro_y <= gy; i_gyro_z <= gz;
        i_accel_x <= ax; i_accel_y <= ay; i_accel_z <= az;
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        g[0] = gx; g[1] = gy; g[2] = gz;
        a[0] = ax; a[1] = ay; a[2] = az;
        predict_attitude(g, a);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_quats.size() != 0) @(negedge i_clk);
        repeat (1000) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == imuacf_pkg::REG_KP) kp_gain = longint'(val);
        else if (idx == imuacf_pkg::REG_KI) ki_gain = longint'(val);
        else if (idx == imuacf_pkg::REG_DT) dt_period = longint'(val);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count, input bit tidy);
        logic signed [15:0] ax, ay, az;
        for (int k = 0; k < count; k++) begin
            if (tidy) begin
                ax = 16'($urandom_range(600) - 300);
                ay = 16'($urandom_range(600) - 300);
                az = 16'(4096 + $urandom_range(600) - 300);
                if ($urandom_range(19) == 0) begin ax = '0; ay = '0; az = '0; end
                send_sample(16'($urandom_range(2000) - 1000), 16'($urandom_range(2000) - 1000),
                            16'($urandom_range(2000) - 1000), ax, ay, az);
            end else begin
                send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_extremes();
        send_sample(0, 0, 0, 0, 0, 16'sd4096);
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0);
        send_sample(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_sample(16'sd1, 0, 0, 16'sd1, 0, 0);
        send_sample(0, 0, 0, 16'sh8000, 0, 0);
        send_sample(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
        drain();
    endtask

    task automatic test_gains();
        write_reg(imuacf_pkg::REG_KP, 16'hffff);
        write_reg(imuacf_pkg::REG_KI, 16'hffff);
        write_reg(imuacf_pkg::REG_DT, 16'hffff);
        send_random(8, 1'b1);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 0, 0, 0);
        drain();
        write_reg(imuacf_pkg::REG_DT, 16'd0);
        write_reg(imuacf_pkg::REG_KP, 16'd0);
        send_random(6, 1'b1);
        drain();
        write_reg(imuacf_pkg::REG_DT, 16'd1);
        write_reg(imuacf_pkg::REG_KI, 16'd0);
        send_random(6, 1'b0);
        drain();
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            write_reg(imuacf_pkg::REG_KP, 16'($urandom_range(16384)));
            write_reg(imuacf_pkg::REG_KI, 16'($urandom_range(4096)));
            write_reg(imuacf_pkg::REG_DT, 16'($urandom_range(65535, 1)));
            send_random(80, 1'b1);
            send_random(20, 1'b0);
            drain();
        end
    endtask

    task automatic test_backpressure();
        rx_holdoff = 3000;
        send_random(6, 1'b1);
        drain();
        send_random(4, 1'b1);
        drain();
    endtask

    task automatic test_steady();
        rx_jitter = 1'b0;
        tx_jitter = 1'b0;
        write_reg(imuacf_pkg::REG_KP, imuacf_pkg::KP_RESET);
        write_reg(imuacf_pkg::REG_DT, imuacf_pkg::DT_RESET);
        send_random(60, 1'b1);
        drain();
    endtask

    initial begin
        kp_gain = longint'(imuacf_pkg::KP_RESET);
        ki_gain = longint'(imuacf_pkg::KI_RESET);
        dt_period = longint'(imuacf_pkg::DT_RESET);
        att[0] = 16384; att[1] = 0; att[2] = 0; att[3] = 0;
        err_int[0] = 0; err_int[1] = 0; err_int[2] = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_gains();
        test_random();
        test_backpressure();
        test_steady();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // receiver stall
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_holdoff > 0) begin
                i_stall <= 1'b1;
                repeat (rx_holdoff) @(negedge i_clk);
                rx_holdoff = 0;
                i_stall <= 1'b0;
            end else if (rx_jitter && $urandom_range(5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(7, 1) - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_quat_beat q;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_quats.size() == 0) begin
                report_mismatch("quaternion beat with none expected");
            end else begin
                q = expected_quats.pop_front();
                if (o_quat_w !== q.w) report_mismatch($sformatf("w %0d exp %0d", o_quat_w, q.w));
                if (o_quat_x !== q.x) report_mismatch($sformatf("x %0d exp %0d", o_quat_x, q.x));
                if (o_quat_y !== q.y) report_mismatch($sformatf("y %0d exp %0d", o_quat_y, q.y));
                if (o_quat_z !== q.z) report_mismatch($sformatf("z %0d exp %0d", o_quat_z, q.z));
                if (o_accel_invalid !== q.bad) report_mismatch("accel_invalid flag");
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end
endmodule
`default_nettype wire
